// File: design/pfms_pkg.sv
// Package: field widths, codes and default sizes for the pattern first-match search.
`timescale 1ns / 1ps

package pfms_pkg;

   localparam int PATTERN_MAX_DEFAULT = 256;
   localparam int BUFFER_MAX_DEFAULT  = 65536;

   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 8;
   localparam int OFFSET_W   = 16;
   localparam int POSITION_W = 16;
   localparam int LENGTH_W   = 9;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic                   req_kind_type;

   localparam csr_index_type REG_PATTERN_LENGTH = csr_index_type'(0);
   localparam csr_index_type REG_SEARCH_ENABLE  = csr_index_type'(1);

   localparam req_kind_type REQ_LOAD = 1'b0;
   localparam req_kind_type REQ_DATA = 1'b1;

endpackage

// File: design/pfms_if.sv
// Interfaces: request, response and register write channels of the pattern search.
`timescale 1ns / 1ps

interface pfms_req_if;
   logic                              valid;
   logic                              ready;
   pfms_pkg::req_kind_type            req_type;
   logic [pfms_pkg::BYTE_W-1:0]       byte_value;
   logic [pfms_pkg::INDEX_W-1:0]      pattern_index;
   logic                              first_byte;
   logic                              last_byte;
   logic [pfms_pkg::OFFSET_W-1:0]     start_offset;

   modport source (output valid, req_type, byte_value, pattern_index, first_byte,
                   last_byte, start_offset, input ready);
   modport sink (input valid, req_type, byte_value, pattern_index, first_byte,
                 last_byte, start_offset, output ready);
endinterface

interface pfms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [pfms_pkg::POSITION_W-1:0]   match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink (input valid, found, match_position, output ready);
endinterface

interface pfms_csr_if;
   logic                              valid;
   logic                              ready;
   pfms_pkg::csr_index_type           index;
   logic [pfms_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/pattern_first_match_search.sv
// Top level: streaming first-match search of a stored pattern in a byte buffer.
//
//   Channel   Direction  Carries
//   req_bus   in         load item (pattern byte) or data item (buffer byte)
//   rsp_bus   out        found flag and match position, one per last data byte
//   csr_bus   in         register writes: pattern length, search enable
//
// An item is taken into an input register, processed while it is held there by a
// full-window compare against the pattern, and its result is held in an output
// register, so one item is accepted per cycle unless a waiting result stalls the input register.
// The window compare (byte rotation plus one compare per pattern slot) sets the cycle.
// Reset is synchronous and clears all control state; the pattern store is not cleared.
// A waiting result holds a last data item in the input register, and new items wait behind it.
`timescale 1ns / 1ps

module pattern_first_match_search #(
   parameter int PATTERN_MAX = pfms_pkg::PATTERN_MAX_DEFAULT,
   parameter int BUFFER_MAX  = pfms_pkg::BUFFER_MAX_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   pfms_req_if.sink    req_bus,
   pfms_rsp_if.source  rsp_bus,
   pfms_csr_if.sink    csr_bus
);

   localparam int WIN_BITS = PATTERN_MAX * pfms_pkg::BYTE_W;
   localparam int CNT_W    = $clog2(BUFFER_MAX + 1);
   localparam int SHIFT_W  = $clog2(PATTERN_MAX + 1);
   localparam int LEN_W    = pfms_pkg::LENGTH_W;
   localparam int POS_W    = pfms_pkg::POSITION_W;
   localparam int OFF_W    = pfms_pkg::OFFSET_W;
   localparam int BYTE_W   = pfms_pkg::BYTE_W;

   // Input register.
   logic                         s1_valid_ff;
   pfms_pkg::req_kind_type       s1_type_ff;
   logic [BYTE_W-1:0]            s1_byte_ff;
   logic [pfms_pkg::INDEX_W-1:0] s1_index_ff;
   logic                         s1_first_ff;
   logic                         s1_last_ff;
   logic [OFF_W-1:0]             s1_start_ff;

   // Search state and registers.
   logic [BYTE_W-1:0]            pat_ff [PATTERN_MAX];
   logic [WIN_BITS-1:0]          win_ff;
   logic [CNT_W-1:0]             count_ff;
   logic                         hit_ff;
   logic [POS_W-1:0]             hit_pos_ff;
   logic [OFF_W-1:0]             saved_start_ff;
   logic [LEN_W-1:0]             pattern_length_ff;
   logic                         search_enable_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic [POS_W-1:0]             rsp_pos_ff;

   // Next-state values.
   logic                         is_data;
   logic                         needs_out;
   logic                         s1_go;
   logic [CNT_W-1:0]             base_count;
   logic                         base_hit;
   logic [POS_W-1:0]             base_pos;
   logic [OFF_W-1:0]             start_in;
   logic                         zero_hit;
   logic                         hit_a;
   logic [POS_W-1:0]             pos_a;
   logic                         store;
   logic                         len_ok;
   logic [CNT_W-1:0]             new_count;
   logic [CNT_W-1:0]             cand_pos;
   logic [WIN_BITS-1:0]          win_in;
   logic [WIN_BITS-1:0]          win_rev;
   logic [WIN_BITS-1:0]          win_aligned;
   logic [SHIFT_W-1:0]           align_amt;
   logic [PATTERN_MAX-1:0]       slot_ok;
   logic                         test_hit;
   logic                         hit_in;
   logic [POS_W-1:0]             hit_pos_in;
   logic [CNT_W-1:0]             count_in;
   logic                         found_in;

   assign is_data   = (s1_type_ff == pfms_pkg::REQ_DATA);
   assign needs_out = s1_valid_ff && is_data && s1_last_ff;
   assign s1_go     = s1_valid_ff && (!needs_out || !rsp_valid_ff || rsp_bus.ready);

   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found          = rsp_found_ff;
   assign rsp_bus.match_position = rsp_pos_ff;

   // A first byte restarts the buffer; an empty pattern can then match at position zero.
   assign base_count = s1_first_ff ? '0 : count_ff;
   assign base_hit   = s1_first_ff ? 1'b0 : hit_ff;
   assign base_pos   = s1_first_ff ? '0 : hit_pos_ff;
   assign start_in   = s1_first_ff ? s1_start_ff : saved_start_ff;
   assign zero_hit   = s1_first_ff && (pattern_length_ff == '0) && (s1_start_ff == '0);
   assign hit_a      = base_hit || zero_hit;
   assign pos_a      = zero_hit ? '0 : base_pos;

   assign len_ok    = int'(pattern_length_ff) <= PATTERN_MAX;
   assign store     = base_count < CNT_W'(BUFFER_MAX);
   assign new_count = base_count + CNT_W'(1);
   assign cand_pos  = new_count - CNT_W'(pattern_length_ff);
   assign win_in    = (win_ff << BYTE_W) | WIN_BITS'(s1_byte_ff);
   assign align_amt = SHIFT_W'(PATTERN_MAX - int'(pattern_length_ff));

   // The newest byte sits in the lowest lane; reversing and shifting puts the
   // candidate's first byte in lane zero, next to pattern slot zero.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_rev[i*BYTE_W +: BYTE_W] = win_in[(PATTERN_MAX-1-i)*BYTE_W +: BYTE_W];
      end
   end

   assign win_aligned = win_rev >> {align_amt, 3'b000};

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         slot_ok[j] = (j >= int'(pattern_length_ff)) ||
                      (win_aligned[j*BYTE_W +: BYTE_W] == pat_ff[j]);
      end
   end

   assign test_hit = store && !hit_a && len_ok &&
                     (new_count >= CNT_W'(pattern_length_ff)) &&
                     (32'(cand_pos) >= 32'(start_in)) && (&slot_ok);
   assign hit_in     = hit_a || test_hit;
   assign hit_pos_in = test_hit ? POS_W'(cand_pos) : pos_a;
   assign count_in   = store ? new_count : base_count;
   assign found_in   = search_enable_ff && hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         count_ff          <= '0;
         hit_ff            <= 1'b0;
         hit_pos_ff        <= '0;
         saved_start_ff    <= '0;
         pattern_length_ff <= '0;
         search_enable_ff  <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_go && is_data) begin
            if (s1_first_ff) begin
               saved_start_ff <= s1_start_ff;
            end
            if (s1_last_ff) begin
               count_ff   <= '0;
               hit_ff     <= 1'b0;
               hit_pos_ff <= '0;
            end else begin
               count_ff   <= count_in;
               hit_ff     <= hit_in;
               hit_pos_ff <= hit_pos_in;
            end
         end

         if (s1_go && needs_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               pfms_pkg::REG_PATTERN_LENGTH: begin
                  pattern_length_ff <= csr_bus.data[LEN_W-1:0];
               end
               pfms_pkg::REG_SEARCH_ENABLE: begin
                  search_enable_ff <= csr_bus.data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_type_ff  <= req_bus.req_type;
         s1_byte_ff  <= req_bus.byte_value;
         s1_index_ff <= req_bus.pattern_index;
         s1_first_ff <= req_bus.first_byte;
         s1_last_ff  <= req_bus.last_byte;
         s1_start_ff <= req_bus.start_offset;
      end
      if (s1_go && needs_out) begin
         rsp_found_ff <= found_in;
         rsp_pos_ff   <= found_in ? hit_pos_in : '0;
      end
      if (s1_go && is_data && store) begin
         win_ff <= win_in;
      end
      for (int e = 0; e < PATTERN_MAX; e++) begin
         if (s1_go && !is_data && (int'(s1_index_ff) == e)) begin
            pat_ff[e] <= s1_byte_ff;
         end
      end
   end

   a_found_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> search_enable_ff)
      else $error("found reported while search is disabled");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_MAX))
      else $error("byte count beyond buffer limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && is_data && s1_last_ff |=> (count_ff == '0) && !hit_ff)
      else $error("buffer state not cleared after last byte");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |-> rsp_valid_ff && !rsp_bus.ready)
      else $error("input stage stalled without a blocked result");

endmodule

// File: bench/pfms_checker.sv
// Checker: follows the three channels, predicts each search result and compares the responses.
`timescale 1ns / 1ps

module pfms_checker (
   input  logic clock,
   input  logic reset,
   pfms_req_if  req_bus,
   pfms_rsp_if  rsp_bus,
   pfms_csr_if  csr_bus,
   output int   failures,
   output int   pending,
   output int   results_checked,
   output int   hits_checked
);

   localparam int WINDOW       = pfms_pkg::PATTERN_MAX_DEFAULT;
   localparam int BUFFER_LIMIT = pfms_pkg::BUFFER_MAX_DEFAULT;

   typedef struct packed {
      logic                            found;
      logic [pfms_pkg::POSITION_W-1:0] position;
   } search_result_type;

   search_result_type           expected_results [$];
   logic [pfms_pkg::BYTE_W-1:0] pattern_copy [WINDOW];
   logic [pfms_pkg::BYTE_W-1:0] recent_bytes [WINDOW];
   int unsigned                 byte_count;
   int unsigned                 hit_at;
   int unsigned                 start_floor;
   int unsigned                 length_setting;
   bit                          hit_flag;
   bit                          enable_setting;

   // Only the one alignment whose match would end after 'count' bytes is tried.
   function automatic void test_match_end(input int unsigned count);
      int unsigned pos;
      bit          equal;
      if (hit_flag || length_setting > WINDOW || count < length_setting) return;
      pos = count - length_setting;
      if (pos < start_floor) return;
      equal = 1'b1;
      for (int unsigned j = 0; j < length_setting; j++)
         if (recent_bytes[(pos + j) % WINDOW] != pattern_copy[j]) equal = 1'b0;
      if (equal) begin
         hit_flag = 1'b1;
         hit_at   = pos;
      end
   endfunction

   function automatic void take_item(input pfms_pkg::req_kind_type kind,
                                     input logic [pfms_pkg::BYTE_W-1:0] value,
                                     input logic [pfms_pkg::INDEX_W-1:0] slot,
                                     input logic first, input logic last,
                                     input logic [pfms_pkg::OFFSET_W-1:0] offset);
      search_result_type outcome;
      if (kind == pfms_pkg::REQ_LOAD) begin
         pattern_copy[slot] = value;
         return;
      end
      if (first) begin
         byte_count  = 0;
         hit_flag    = 1'b0;
         hit_at      = 0;
         start_floor = offset;
         test_match_end(0);
      end
      if (byte_count < BUFFER_LIMIT) begin
         recent_bytes[byte_count % WINDOW] = value;
         byte_count++;
         test_match_end(byte_count);
      end
      if (!last) return;
      outcome.found    = enable_setting && hit_flag;
      outcome.position = outcome.found ? pfms_pkg::POSITION_W'(hit_at) : '0;
      expected_results.push_back(outcome);
      byte_count = 0;
      hit_flag   = 1'b0;
      hit_at     = 0;
   endfunction

   always @(posedge clock) begin : monitor
      search_result_type want;
      if (reset) begin
         expected_results.delete();
         for (int k = 0; k < WINDOW; k++) recent_bytes[k] = '0;
         byte_count      = 0;
         hit_flag        = 1'b0;
         hit_at          = 0;
         start_floor     = 0;
         length_setting  = 0;
         enable_setting  = 1'b0;
         failures        = 0;
         results_checked = 0;
         hits_checked    = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (rsp_bus.found === 1'b1) hits_checked++;
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: result with none expected, found %0b position %0d", $time,
                        rsp_bus.found, rsp_bus.match_position);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.found !== want.found) begin
                  failures++;
                  $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found,
                           rsp_bus.found);
               end
               if (rsp_bus.match_position !== want.position) begin
                  failures++;
                  $display("%0t: match_position mismatch, expected %0d, got %0d", $time,
                           want.position, rsp_bus.match_position);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            take_item(req_bus.req_type, req_bus.byte_value, req_bus.pattern_index,
                      req_bus.first_byte, req_bus.last_byte, req_bus.start_offset);
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               pfms_pkg::REG_PATTERN_LENGTH:
                  length_setting = 32'(csr_bus.data[pfms_pkg::LENGTH_W-1:0]);
               pfms_pkg::REG_SEARCH_ENABLE: enable_setting = csr_bus.data[0];
               default: ;
            endcase
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: bench/testbench.sv
// Testbench top: drives pattern loads, buffers and register writes and gives the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1500;

   logic clock;
   logic reset;

   pfms_req_if req_bus ();
   pfms_rsp_if rsp_bus ();
   pfms_csr_if csr_bus ();

   int failures;
   int pending;
   int results_checked;
   int hits_checked;

   pattern_first_match_search uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pfms_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked),
      .hits_checked    (hits_checked)
   );

   bit                          pattern_written [pfms_pkg::PATTERN_MAX_DEFAULT];
   logic [pfms_pkg::BYTE_W-1:0] pattern_shadow  [pfms_pkg::PATTERN_MAX_DEFAULT];
   int                          burst_left;
   int                          items_sent;
   int                          buffers_sent;
   int                          writes_done;
   int                          current_length;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin : receiver
      int span;
      int mode;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 80);
         for (int step = 0; step < span; step++) begin
            @(negedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (step >= 15);
            endcase
         end
      end
   end

   function automatic logic [pfms_pkg::BYTE_W-1:0] pick_byte();
      if ($urandom_range(0, 1)) return 8'($urandom_range(8'h40, 8'h43));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_next_length();
      int prefix;
      prefix = 0;
      while (prefix < pfms_pkg::PATTERN_MAX_DEFAULT && pattern_written[prefix]) prefix++;
      case ($urandom_range(0, 4))
         0: return 0;
         1: return $urandom_range(pfms_pkg::PATTERN_MAX_DEFAULT + 1, 511);
         default: return (prefix == 0) ? 0 : $urandom_range(1, prefix);
      endcase
   endfunction

   task automatic send_item(input pfms_pkg::req_kind_type kind,
                            input logic [pfms_pkg::BYTE_W-1:0] value,
                            input logic [pfms_pkg::INDEX_W-1:0] slot, input logic first,
                            input logic last, input logic [pfms_pkg::OFFSET_W-1:0] offset);
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 32);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.byte_value    <= value;
      req_bus.pattern_index <= slot;
      req_bus.first_byte    <= first;
      req_bus.last_byte     <= last;
      req_bus.start_offset  <= offset;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      items_sent++;
      if (kind == pfms_pkg::REQ_LOAD) begin
         pattern_written[slot] = 1'b1;
         pattern_shadow[slot]  = value;
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input pfms_pkg::csr_index_type index, input int value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= pfms_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
      writes_done++;
   endtask

   task automatic configure(input int length, input bit enable);
      wait_drained();
      if ($urandom_range(0, 1)) begin
         write_register(pfms_pkg::REG_SEARCH_ENABLE, enable);
         write_register(pfms_pkg::REG_PATTERN_LENGTH, length);
      end else begin
         write_register(pfms_pkg::REG_PATTERN_LENGTH, length);
         write_register(pfms_pkg::REG_SEARCH_ENABLE, enable);
      end
      current_length = length;
   endtask

   task automatic load_pattern(input int length);
      bit descending;
      descending = $urandom_range(0, 1);
      for (int k = 0; k < length; k++)
         send_item(pfms_pkg::REQ_LOAD, pick_byte(), 8'(descending ? length - 1 - k : k),
                   1'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // Most buffers are well formed; a few drop the first flag, restart in the middle,
   // change the pattern length midway or are plain noise.
   task automatic send_buffer();
      logic [pfms_pkg::BYTE_W-1:0]   content [0:511];
      logic [pfms_pkg::OFFSET_W-1:0] offset;
      logic                          first;
      int                            n;
      int                            style;
      int                            at;
      int                            pick;
      int                            restart_at;
      int                            change_at;
      style = $urandom_range(0, 19);
      if (style == 19) begin
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++)
            send_item($urandom_range(0, 1) ? pfms_pkg::REQ_LOAD : pfms_pkg::REQ_DATA,
                      8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                      16'($urandom));
         return;
      end
      if (current_length > 16 && current_length <= pfms_pkg::PATTERN_MAX_DEFAULT)
         n = current_length + $urandom_range(0, 40);
      else
         n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) content[i] = pick_byte();
      if (current_length >= 1 && current_length <= pfms_pkg::PATTERN_MAX_DEFAULT &&
          n >= current_length)
         repeat ($urandom_range(0, 2)) begin
            at = ($urandom_range(0, 2) == 0) ? n - current_length
                                             : $urandom_range(0, n - current_length);
            for (int j = 0; j < current_length; j++) content[at + j] = pattern_shadow[j];
            if ($urandom_range(0, 3) == 0)
               content[at + $urandom_range(0, current_length - 1)] ^= 8'h01;
         end
      pick = $urandom_range(0, 9);
      if (pick < 4)
         offset = '0;
      else if (pick < 7)
         offset = 16'($urandom_range(0, n));
      else if (pick == 7)
         offset = (current_length <= n) ? 16'(n - current_length) : 16'(n);
      else if (pick == 8)
         offset = 16'($urandom_range(0, 65535));
      else
         offset = 16'(n + 1);
      restart_at = (style == 17 && n > 2) ? $urandom_range(1, n - 1) : -1;
      change_at  = (style == 16) ? n / 2 : -1;
      for (int i = 0; i < n; i++) begin
         if (i == change_at) configure(pick_next_length(), $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 39) == 0)
            send_item(pfms_pkg::REQ_LOAD, pick_byte(), 8'($urandom), 1'($urandom),
                      1'($urandom), 16'($urandom));
         first = (i == 0 && style != 18) || i == restart_at;
         send_item(pfms_pkg::REQ_DATA, content[i], 8'($urandom), first, i == n - 1,
                   first ? offset : 16'($urandom));
      end
      buffers_sent++;
   endtask

   initial begin : stimulus
      int random_start;
      int length;
      int r;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = pfms_pkg::REQ_LOAD;
      req_bus.byte_value    = '0;
      req_bus.pattern_index = '0;
      req_bus.first_byte    = 1'b0;
      req_bus.last_byte     = 1'b0;
      req_bus.start_offset  = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = pfms_pkg::REG_PATTERN_LENGTH;
      csr_bus.data          = '0;
      burst_left            = 0;
      items_sent            = 0;
      buffers_sent          = 0;
      writes_done           = 0;
      current_length        = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Search disabled after reset, then the empty pattern against several offsets.
      send_item(pfms_pkg::REQ_DATA, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000);
      configure(0, 1'b1);
      send_item(pfms_pkg::REQ_DATA, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h12, 8'h00, 1'b1, 1'b0, 16'd3);
      send_item(pfms_pkg::REQ_DATA, 8'h34, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h56, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h12, 8'h00, 1'b1, 1'b0, 16'd4);
      send_item(pfms_pkg::REQ_DATA, 8'h34, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h56, 8'h00, 1'b0, 1'b1, 16'h0000);

      send_item(pfms_pkg::REQ_LOAD, 8'h00, 8'd0, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_LOAD, 8'hFF, 8'd1, 1'b1, 1'b1, 16'hFFFF);
      send_item(pfms_pkg::REQ_LOAD, 8'hA5, 8'd2, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_LOAD, 8'h5A, 8'd255, 1'b0, 1'b0, 16'h0000);
      configure(3, 1'b1);

      // A match that ends on the final byte, then the highest start offset.
      send_item(pfms_pkg::REQ_DATA, 8'h11, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hA5, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'h00, 8'h00, 1'b1, 1'b0, 16'hFFFF);
      send_item(pfms_pkg::REQ_DATA, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hA5, 8'h00, 1'b0, 1'b1, 16'h0000);

      // No first flag: the buffer continues with the offset kept from before.
      send_item(pfms_pkg::REQ_DATA, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hA5, 8'h00, 1'b0, 1'b1, 16'h0000);

      configure(511, 1'b1);
      send_item(pfms_pkg::REQ_DATA, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000);
      send_item(pfms_pkg::REQ_DATA, 8'hA5, 8'h00, 1'b0, 1'b1, 16'h0000);

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r < 2)
            length = 0;
         else if (r < 12)
            length = $urandom_range(1, 6);
         else if (r < 16)
            length = $urandom_range(7, 40);
         else if (r == 16)
            length = $urandom_range(200, pfms_pkg::PATTERN_MAX_DEFAULT);
         else if (r == 17)
            length = pfms_pkg::PATTERN_MAX_DEFAULT;
         else
            length = $urandom_range(pfms_pkg::PATTERN_MAX_DEFAULT + 1, 511);
         if (length >= 1 && length <= pfms_pkg::PATTERN_MAX_DEFAULT) load_pattern(length);
         configure(length, $urandom_range(0, 4) != 0);
         repeat ($urandom_range(3, 8)) begin
            send_buffer();
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
      end

      wait_drained();
      $display("Run covered %0d items in %0d buffers with %0d register writes,", items_sent,
               buffers_sent, writes_done);
      $display("with empty, full and too long patterns; %0d results compared, %0d matches.",
               results_checked, hits_checked);
      if (failures == 0 && pending == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: pattern_first_match_search.f
design/pfms_pkg.sv
design/pfms_if.sv
design/pattern_first_match_search.sv
bench/pfms_checker.sv
bench/testbench.sv
